// File: rtl/dpalu_pkg.sv
// Shared types, opcodes and a rotate helper function for the data-processing ALU.
`timescale 1ns / 1ps
`default_nettype none

package dpalu_pkg;

   // Data-processing opcodes, instruction bits 24:21
   localparam logic [3:0] OP_AND = 4'd0;
   localparam logic [3:0] OP_EOR = 4'd1;
   localparam logic [3:0] OP_SUB = 4'd2;
   localparam logic [3:0] OP_RSB = 4'd3;
   localparam logic [3:0] OP_ADD = 4'd4;
   localparam logic [3:0] OP_ADC = 4'd5;
   localparam logic [3:0] OP_SBC = 4'd6;
   localparam logic [3:0] OP_RSC = 4'd7;
   localparam logic [3:0] OP_TST = 4'd8;
   localparam logic [3:0] OP_TEQ = 4'd9;
   localparam logic [3:0] OP_CMP = 4'd10;
   localparam logic [3:0] OP_CMN = 4'd11;
   localparam logic [3:0] OP_ORR = 4'd12;
   localparam logic [3:0] OP_MOV = 4'd13;
   localparam logic [3:0] OP_BIC = 4'd14;
   localparam logic [3:0] OP_MVN = 4'd15;

   // Barrel shift types, instruction bits 6:5
   localparam logic [1:0] SHIFT_LSL = 2'd0;
   localparam logic [1:0] SHIFT_LSR = 2'd1;
   localparam logic [1:0] SHIFT_ASR = 2'd2;
   localparam logic [1:0] SHIFT_ROR = 2'd3;

   // Register number of the program counter
   localparam logic [3:0] REG_PC = 4'd15;

   // Register shift amount that still produces a defined carry
   localparam logic [7:0] SHIFT_FULL = 8'd32;

   typedef struct packed {
      logic [31:0] instr_word;
      logic [31:0] rn_value;
      logic [31:0] rm_value;
      logic [7:0]  rs_low_byte;
      logic        has_saved_status;
      logic [31:0] saved_status;
   } req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic [3:0]  dest_reg;
      logic        dest_write;
      logic [3:0]  flags_after;
      logic        restore_status;
      logic        unpredictable;
   } rsp_type;

   // Operand 2 and the shifter carry-out
   typedef struct packed {
      logic [31:0] operand;
      logic        carry;
   } shift_out_type;

   // Rotate right by 0..31
   function automatic logic [31:0] rotr32(input logic [31:0] value, input logic [4:0] amount);
      logic [63:0] wide;
      wide = {value, value} >> amount;
      return wide[31:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/dpalu_shifter.sv
// Operand 2 generation: rotated immediate or barrel-shifted Rm with carry-out.
`timescale 1ns / 1ps
`default_nettype none

module dpalu_shifter (
   input  wire logic [31:0]            instr_word,
   input  wire logic [31:0]            rm_value,
   input  wire logic [7:0]             rs_low_byte,
   input  wire logic                   carry_in,
   output dpalu_pkg::shift_out_type    shift_out
);
   import dpalu_pkg::*;

   logic [1:0]  shift_kind;
   logic [4:0]  imm_amt;
   logic [4:0]  rot_amt;
   logic [4:0]  reg_amt;
   logic [4:0]  lsl_imm_idx;
   logic [4:0]  lsl_reg_idx;
   logic [31:0] imm_operand;
   logic [31:0] sign_fill;
   logic        rs_zero;
   logic        rs_below;
   logic        rs_full;

   assign shift_kind  = instr_word[6:5];
   assign imm_amt     = instr_word[11:7];
   assign rot_amt     = {instr_word[11:8], 1'b0};
   assign reg_amt     = rs_low_byte[4:0];
   assign lsl_imm_idx = 5'(6'd32 - {1'b0, imm_amt});
   assign lsl_reg_idx = 5'(6'd32 - {1'b0, reg_amt});
   assign imm_operand = rotr32({24'd0, instr_word[7:0]}, rot_amt);
   assign sign_fill   = {32{rm_value[31]}};
   assign rs_zero     = (rs_low_byte == 8'd0);
   assign rs_below    = (rs_low_byte < SHIFT_FULL);
   assign rs_full     = (rs_low_byte == SHIFT_FULL);

   // Select operand 2 and its carry
   always_comb begin
      shift_out.operand = rm_value;
      shift_out.carry   = carry_in;
      if (instr_word[25]) begin
         // Rotated 8-bit immediate
         shift_out.operand = imm_operand;
         shift_out.carry   = (rot_amt == 5'd0) ? carry_in : imm_operand[31];
      end else if (!instr_word[4]) begin
         // Shift by immediate amount; zero has special meanings
         unique case (shift_kind)
            SHIFT_LSL: begin
               if (imm_amt != 5'd0) begin
                  shift_out.operand = rm_value << imm_amt;
                  shift_out.carry   = rm_value[lsl_imm_idx];
               end
            end
            SHIFT_LSR: begin
               if (imm_amt == 5'd0) begin
                  shift_out.operand = 32'd0;
                  shift_out.carry   = rm_value[31];
               end else begin
                  shift_out.operand = rm_value >> imm_amt;
                  shift_out.carry   = rm_value[imm_amt - 5'd1];
               end
            end
            SHIFT_ASR: begin
               if (imm_amt == 5'd0) begin
                  shift_out.operand = sign_fill;
                  shift_out.carry   = rm_value[31];
               end else begin
                  shift_out.operand = 32'($signed(rm_value) >>> imm_amt);
                  shift_out.carry   = rm_value[imm_amt - 5'd1];
               end
            end
            default: begin
               if (imm_amt == 5'd0) begin
                  // RRX
                  shift_out.operand = {carry_in, rm_value[31:1]};
                  shift_out.carry   = rm_value[0];
               end else begin
                  shift_out.operand = rotr32(rm_value, imm_amt);
                  shift_out.carry   = rm_value[imm_amt - 5'd1];
               end
            end
         endcase
      end else if (!rs_zero) begin
         // Shift by register amount; zero passes Rm and C through
         unique case (shift_kind)
            SHIFT_LSL: begin
               if (rs_below) begin
                  shift_out.operand = rm_value << reg_amt;
                  shift_out.carry   = rm_value[lsl_reg_idx];
               end else begin
                  shift_out.operand = 32'd0;
                  shift_out.carry   = rs_full & rm_value[0];
               end
            end
            SHIFT_LSR: begin
               if (rs_below) begin
                  shift_out.operand = rm_value >> reg_amt;
                  shift_out.carry   = rm_value[reg_amt - 5'd1];
               end else begin
                  shift_out.operand = 32'd0;
                  shift_out.carry   = rs_full & rm_value[31];
               end
            end
            SHIFT_ASR: begin
               if (rs_below) begin
                  shift_out.operand = 32'($signed(rm_value) >>> reg_amt);
                  shift_out.carry   = rm_value[reg_amt - 5'd1];
               end else begin
                  shift_out.operand = sign_fill;
                  shift_out.carry   = rm_value[31];
               end
            end
            default: begin
               if (reg_amt == 5'd0) begin
                  // Multiple of 32: value unchanged, carry is the top bit
                  shift_out.operand = rm_value;
                  shift_out.carry   = rm_value[31];
               end else begin
                  shift_out.operand = rotr32(rm_value, reg_amt);
                  shift_out.carry   = rm_value[reg_amt - 5'd1];
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/dpalu_core.sv
// ALU operations, flag generation and status restore for one instruction.
`timescale 1ns / 1ps
`default_nettype none

module dpalu_core (
   input  wire dpalu_pkg::req_type       req,
   input  wire dpalu_pkg::shift_out_type shift_out,
   input  wire logic [3:0]               flags_in,
   output dpalu_pkg::rsp_type            rsp,
   output logic [3:0]                    flags_out
);
   import dpalu_pkg::*;

   logic [3:0]  opcode;
   logic        set_flags;
   logic [3:0]  rd;
   logic        carry_flag;
   logic        overflow_flag;
   logic        is_compare;
   logic        is_arith;
   logic [31:0] op2;
   logic [31:0] add_a;
   logic [31:0] add_b;
   logic        add_cin;
   logic [32:0] add_sum;
   logic        add_v;
   logic [31:0] result;
   logic        c_new;
   logic        v_new;

   assign opcode        = req.instr_word[24:21];
   assign set_flags     = req.instr_word[20];
   assign rd            = req.instr_word[15:12];
   assign carry_flag    = flags_in[1];
   assign overflow_flag = flags_in[0];
   assign op2           = shift_out.operand;

   // Adder operand selection
   always_comb begin
      add_a    = req.rn_value;
      add_b    = op2;
      add_cin  = 1'b0;
      is_arith = 1'b1;
      case (opcode)
         OP_SUB, OP_CMP: begin
            add_b   = ~op2;
            add_cin = 1'b1;
         end
         OP_RSB: begin
            add_a   = op2;
            add_b   = ~req.rn_value;
            add_cin = 1'b1;
         end
         OP_ADD, OP_CMN: begin
            add_cin = 1'b0;
         end
         OP_ADC: begin
            add_cin = carry_flag;
         end
         OP_SBC: begin
            add_b   = ~op2;
            add_cin = carry_flag;
         end
         OP_RSC: begin
            add_a   = op2;
            add_b   = ~req.rn_value;
            add_cin = carry_flag;
         end
         default: begin
            is_arith = 1'b0;
         end
      endcase
   end

   assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
   assign add_v   = (add_a[31] ^ add_sum[31]) & (add_b[31] ^ add_sum[31]);

   // Result selection
   always_comb begin
      unique case (opcode)
         OP_AND, OP_TST: result = req.rn_value & op2;
         OP_EOR, OP_TEQ: result = req.rn_value ^ op2;
         OP_ORR:         result = req.rn_value | op2;
         OP_MOV:         result = op2;
         OP_BIC:         result = req.rn_value & ~op2;
         OP_MVN:         result = ~op2;
         default:        result = add_sum[31:0];
      endcase
   end

   assign is_compare = (opcode == OP_TST) || (opcode == OP_TEQ) ||
                       (opcode == OP_CMP) || (opcode == OP_CMN);
   assign c_new      = is_arith ? add_sum[32] : shift_out.carry;
   assign v_new      = is_arith ? add_v : overflow_flag;

   // Flag update and status restore
   always_comb begin
      flags_out           = flags_in;
      rsp.restore_status  = 1'b0;
      rsp.unpredictable   = 1'b0;
      if (is_compare || (set_flags && (rd != REG_PC))) begin
         flags_out = {result[31], (result == 32'd0), c_new, v_new};
      end else if (set_flags) begin
         if (req.has_saved_status) begin
            flags_out          = req.saved_status[31:28];
            rsp.restore_status = 1'b1;
         end else begin
            rsp.unpredictable  = 1'b1;
         end
      end
      rsp.result_value = result;
      rsp.dest_reg     = rd;
      rsp.dest_write   = !is_compare;
      rsp.flags_after  = flags_out;
   end

endmodule

`default_nettype wire

// File: rtl/dp_alu_barrel_shifter.sv
// Top level: data-processing ALU with barrel shifter and NZCV flag register.
//
// Usage:
//   The request channel (req_valid, req_stall, req_data) carries one
//   data-processing instruction word with its Rn, Rm, Rs byte and saved
//   status operands. A transfer happens on a rising edge with valid high
//   and stall low. The response channel (rsp_valid, rsp_stall, rsp_data)
//   returns one result per instruction, in order.
//   A transferred request is captured in the input register; the result
//   is registered in the result register once that register is free and
//   is offered on rsp_data from then on. Throughput: one instruction per
//   cycle while the receiver does not stall; the flag register is read and
//   written in the single ALU pass between the input register and the
//   result register, so dependent instructions also issue every cycle.
//   Reset (synchronous, active high) empties both registers and clears
//   NZCV. When the receiver stalls, the result register holds; the input
//   register still takes one more request, and req_stall rises once both
//   registers are occupied.
`timescale 1ns / 1ps
`default_nettype none

module dp_alu_barrel_shifter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire dpalu_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dpalu_pkg::rsp_type     rsp_data
);
   import dpalu_pkg::*;

   logic          s1_valid_ff;
   logic          s1_valid_in;
   req_type       s1_data_ff;
   req_type       s1_data_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_data_ff;
   rsp_type       rsp_data_in;
   logic [3:0]    nzcv_ff;
   logic [3:0]    nzcv_in;
   logic          out_free;
   logic          advance;
   logic          req_accept;
   shift_out_type shift_out;
   rsp_type       alu_rsp;
   logic [3:0]    alu_flags;

   // Handshake control
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign s1_data_in   = req_accept ? req_data : s1_data_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = advance ? alu_rsp : rsp_data_ff;
   assign nzcv_in      = advance ? alu_flags : nzcv_ff;

   // Operand 2
   dpalu_shifter u_shifter (
      .instr_word  (s1_data_ff.instr_word),
      .rm_value    (s1_data_ff.rm_value),
      .rs_low_byte (s1_data_ff.rs_low_byte),
      .carry_in    (nzcv_ff[1]),
      .shift_out   (shift_out)
   );

   // ALU and flags
   dpalu_core u_core (
      .req       (s1_data_ff),
      .shift_out (shift_out),
      .flags_in  (nzcv_ff),
      .rsp       (alu_rsp),
      .flags_out (alu_flags)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         nzcv_ff      <= 4'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         nzcv_ff      <= nzcv_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Stall only when the input register is occupied
   assert property (@(posedge clock) disable iff (reset) req_stall |-> s1_valid_ff)
      else $error("req_stall with empty input register");

   // Reset leaves both registers empty and flags clear
   assert property (@(posedge clock) $past(reset) |-> (nzcv_ff == 4'd0 && !rsp_valid_ff &&
                                                       !s1_valid_ff))
      else $error("state not cleared after reset");

   // Flags only move when an instruction passes into the result register
   assert property (@(posedge clock) disable iff (reset) !advance |=> $stable(nzcv_ff))
      else $error("flags changed without an instruction");

   // Registered flags match the flags reported with the newest result
   assert property (@(posedge clock) disable iff (reset)
                    advance |=> (rsp_data_ff.flags_after == nzcv_ff))
      else $error("reported flags differ from flag register");

   // Restore and unpredictable exclude each other
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff |-> !(rsp_data_ff.restore_status &&
                                       rsp_data_ff.unpredictable))
      else $error("restore and unpredictable both set");

endmodule

`default_nettype wire

// File: bench/dp_alu_barrel_shifter_test.sv
// Testbench for dp_alu_barrel_shifter: directed table plus random instructions.
`timescale 1ns / 1ps

module dp_alu_barrel_shifter_test;
   import dpalu_pkg::*;

   localparam int RANDOM_ITEMS = 700;
   localparam int HOLD_AT      = 220;     // random item that starts the long receiver hold
   localparam int HOLD_BURST   = 16;      // back-to-back items offered during the hold
   localparam int LONG_HOLD    = 60;      // receiver hold length in cycles
   localparam int DRAIN_AT     = 450;     // random item before which the sender drains
   localparam int DRAIN_CYCLES = 8;       // quiet cycles after the last result
   localparam int CYCLE_LIMIT  = 150000;
   localparam int MAX_REPORTS  = 50;

   typedef struct {
      req_type stim;
      logic    exact;
      rsp_type want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [3:0]   flag_state = 4'b0000;
   rsp_type      pending_results[$];
   stim_row_type directed_rows[$];
   logic         long_hold_req = 1'b0;
   int           fail_count = 0;
   int           items_sent = 0;
   int           results_checked = 0;
   int           restores_seen = 0;
   int           unpredictables_seen = 0;
   int           cycle_count = 0;

   dp_alu_barrel_shifter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Predictor: operand 2, barrel shifter, ALU and NZCV update
   // ---------------------------------------------------------------

   function automatic logic [31:0] ror_word(input logic [31:0] value, input int amount);
      if (amount % 32 == 0)
         return value;
      return (value >> (amount % 32)) | (value << (32 - amount % 32));
   endfunction

   function automatic shift_out_type shift_operand(input logic [31:0] ins,
                                                   input logic [31:0] rm,
                                                   input logic [7:0] rs,
                                                   input logic cin);
      shift_out_type so;
      logic [1:0]    kind;
      int            amt;
      kind = ins[6:5];
      if (!ins[4]) begin
         // immediate amount; zero encodes the long forms
         amt = ins[11:7];
         if (amt == 0) begin
            case (kind)
               SHIFT_LSL: begin so.carry = cin;   so.operand = rm;              end
               SHIFT_LSR: begin so.carry = rm[31]; so.operand = '0;             end
               SHIFT_ASR: begin so.carry = rm[31]; so.operand = {32{rm[31]}};   end
               default:   begin so.carry = rm[0];  so.operand = {cin, rm[31:1]}; end
            endcase
         end else begin
            case (kind)
               SHIFT_LSL: begin so.carry = rm[32 - amt]; so.operand = rm << amt; end
               SHIFT_LSR: begin so.carry = rm[amt - 1];  so.operand = rm >> amt; end
               SHIFT_ASR: begin
                  so.carry = rm[amt - 1];
                  so.operand = $signed(rm) >>> amt;
               end
               default: begin
                  so.carry = rm[amt - 1];
                  so.operand = ror_word(rm, amt);
               end
            endcase
         end
      end else begin
         // register amount from the low byte of Rs
         amt = rs;
         if (amt == 0) begin
            so.carry = cin;
            so.operand = rm;
         end else begin
            case (kind)
               SHIFT_LSL: begin
                  if (amt < 32) begin
                     so.carry = rm[32 - amt];
                     so.operand = rm << amt;
                  end else begin
                     so.carry = (amt == 32) ? rm[0] : 1'b0;
                     so.operand = '0;
                  end
               end
               SHIFT_LSR: begin
                  if (amt < 32) begin
                     so.carry = rm[amt - 1];
                     so.operand = rm >> amt;
                  end else begin
                     so.carry = (amt == 32) ? rm[31] : 1'b0;
                     so.operand = '0;
                  end
               end
               SHIFT_ASR: begin
                  if (amt < 32) begin
                     so.carry = rm[amt - 1];
                     so.operand = $signed(rm) >>> amt;
                  end else begin
                     so.carry = rm[31];
                     so.operand = {32{rm[31]}};
                  end
               end
               default: begin
                  if (amt % 32 == 0) begin
                     so.carry = rm[31];
                     so.operand = rm;
                  end else begin
                     so.carry = rm[amt % 32 - 1];
                     so.operand = ror_word(rm, amt);
                  end
               end
            endcase
         end
      end
      return so;
   endfunction

   // {carry, overflow, sum}
   function automatic logic [33:0] add_with_flags(input logic [31:0] a, input logic [31:0] b,
                                                  input logic cin);
      logic [32:0] total;
      logic        ovf;
      total = {1'b0, a} + {1'b0, b} + {32'b0, cin};
      ovf = (a[31] ^ total[31]) & (b[31] ^ total[31]);
      return {total[32], ovf, total[31:0]};
   endfunction

   // Executes one instruction against the tracked flags
   function automatic rsp_type execute_instr(input req_type r);
      rsp_type       res_item;
      shift_out_type so;
      logic [3:0]    op;
      logic [3:0]    rd;
      logic          set_flags, cf, vf, c, v, sc, arith, compare;
      logic [31:0]   op2, res, rn;
      int            rot;
      op = r.instr_word[24:21];
      set_flags = r.instr_word[20];
      rd = r.instr_word[15:12];
      rn = r.rn_value;
      cf = flag_state[1];
      vf = flag_state[0];
      c = cf;
      v = vf;
      arith = 1'b0;
      compare = (op == OP_TST) || (op == OP_TEQ) || (op == OP_CMP) || (op == OP_CMN);

      if (r.instr_word[25]) begin
         rot = r.instr_word[11:8] * 2;
         op2 = ror_word({24'b0, r.instr_word[7:0]}, rot);
         sc = (rot == 0) ? cf : op2[31];
      end else begin
         so = shift_operand(r.instr_word, r.rm_value, r.rs_low_byte, cf);
         op2 = so.operand;
         sc = so.carry;
      end

      case (op)
         OP_AND, OP_TST: res = rn & op2;
         OP_EOR, OP_TEQ: res = rn ^ op2;
         OP_SUB, OP_CMP: begin {c, v, res} = add_with_flags(rn, ~op2, 1'b1); arith = 1'b1; end
         OP_RSB:         begin {c, v, res} = add_with_flags(op2, ~rn, 1'b1); arith = 1'b1; end
         OP_ADD, OP_CMN: begin {c, v, res} = add_with_flags(rn, op2, 1'b0);  arith = 1'b1; end
         OP_ADC:         begin {c, v, res} = add_with_flags(rn, op2, cf);    arith = 1'b1; end
         OP_SBC:         begin {c, v, res} = add_with_flags(rn, ~op2, cf);   arith = 1'b1; end
         OP_RSC:         begin {c, v, res} = add_with_flags(op2, ~rn, cf);   arith = 1'b1; end
         OP_ORR:         res = rn | op2;
         OP_MOV:         res = op2;
         OP_BIC:         res = rn & ~op2;
         default:        res = ~op2;
      endcase
      // logical ops take the shifter carry and keep V
      if (!arith) begin
         c = sc;
         v = vf;
      end

      res_item.restore_status = 1'b0;
      res_item.unpredictable = 1'b0;
      if (compare || (set_flags && rd != REG_PC)) begin
         flag_state = {res[31], res == 32'h0, c, v};
      end else if (set_flags) begin
         // S with the PC as destination
         if (r.has_saved_status) begin
            flag_state = r.saved_status[31:28];
            res_item.restore_status = 1'b1;
         end else begin
            res_item.unpredictable = 1'b1;
         end
      end

      res_item.result_value = res;
      res_item.dest_reg = rd;
      res_item.dest_write = !compare;
      res_item.flags_after = flag_state;
      return res_item;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   function automatic logic [31:0] dp_word(input logic imm_form, input logic [3:0] op,
                                           input logic set_flags, input logic [3:0] rd,
                                           input logic [11:0] operand2);
      return {4'hE, 2'b00, imm_form, op, set_flags, 4'h1, rd, operand2};
   endfunction

   function automatic logic [11:0] rot_imm(input logic [3:0] rot, input logic [7:0] imm8);
      return {rot, imm8};
   endfunction

   function automatic logic [11:0] imm_shift(input logic [4:0] amt, input logic [1:0] kind);
      return {amt, kind, 1'b0, 4'h2};
   endfunction

   function automatic logic [11:0] reg_shift(input logic [1:0] kind);
      return {4'h3, 1'b0, kind, 1'b1, 4'h2};
   endfunction

   task automatic add_row(input logic [31:0] word, input logic [31:0] rn,
                          input logic [31:0] rm, input logic [7:0] rs,
                          input logic has_sp, input logic [31:0] sp,
                          input logic exact, input rsp_type want);
      stim_row_type row;
      row.stim = {word, rn, rm, rs, has_sp, sp};
      row.exact = exact;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   // Corner values show up often in operands
   function automatic logic [31:0] operand_word();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [7:0] shift_amount();
      case ($urandom_range(0, 6))
         0:       return 8'd0;
         1:       return 8'd32;
         2:       return {3'($urandom_range(1, 7)), 5'b0};
         3:       return 8'($urandom_range(1, 31));
         4:       return 8'($urandom_range(33, 255));
         default: return 8'($urandom());
      endcase
   endfunction

   function automatic req_type random_instr();
      req_type r;
      r.instr_word = $urandom();
      if ($urandom_range(0, 9) < 2)
         r.instr_word[15:12] = REG_PC;
      if ($urandom_range(0, 6) == 0)
         r.instr_word[11:7] = 5'd0;
      r.rn_value = operand_word();
      r.rm_value = operand_word();
      r.rs_low_byte = shift_amount();
      r.has_saved_status = 1'($urandom_range(0, 1));
      r.saved_status = $urandom();
      return r;
   endfunction

   // One transfer on the request channel, then record what it should produce
   task automatic send_item(input req_type stim, input logic exact, input rsp_type want);
      rsp_type predicted;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= stim;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = execute_instr(stim);
      pending_results.push_back(exact ? want : predicted);
      items_sent++;
   endtask

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // ---------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------
   initial begin
      int burst_left;
      burst_left = 0;

      // table: exact rows first, they rely on flags cleared by reset
      add_row(dp_word(1'b1, OP_MOV, 1'b1, 4'd0, rot_imm(4'd0, 8'h00)), 32'h1234_5678,
              32'h0, 8'd0, 1'b0, 32'h0, 1'b1, {32'h0, 4'd0, 1'b1, 4'b0100, 1'b0, 1'b0});
      add_row(dp_word(1'b1, OP_MVN, 1'b1, 4'd1, rot_imm(4'd0, 8'h00)), 32'h0,
              32'h0, 8'd0, 1'b0, 32'h0, 1'b1,
              {32'hFFFF_FFFF, 4'd1, 1'b1, 4'b1000, 1'b0, 1'b0});
      add_row(dp_word(1'b1, OP_MOV, 1'b1, REG_PC, rot_imm(4'd0, 8'h00)), 32'h0,
              32'h0, 8'd0, 1'b0, 32'hF000_0000, 1'b1,
              {32'h0, REG_PC, 1'b1, 4'b1000, 1'b0, 1'b1});
      add_row(dp_word(1'b1, OP_MOV, 1'b1, REG_PC, rot_imm(4'd0, 8'h00)), 32'h0,
              32'h0, 8'd0, 1'b1, 32'hF000_0000, 1'b1,
              {32'h0, REG_PC, 1'b1, 4'b1111, 1'b1, 1'b0});
      add_row(dp_word(1'b1, OP_ADD, 1'b1, 4'd2, rot_imm(4'd0, 8'h01)), 32'hFFFF_FFFF,
              32'h0, 8'd0, 1'b0, 32'h0, 1'b1, {32'h0, 4'd2, 1'b1, 4'b0110, 1'b0, 1'b0});
      add_row(dp_word(1'b1, OP_SUB, 1'b1, 4'd3, rot_imm(4'd0, 8'h01)), 32'h8000_0000,
              32'h0, 8'd0, 1'b0, 32'h0, 1'b1,
              {32'h7FFF_FFFF, 4'd3, 1'b1, 4'b0011, 1'b0, 1'b0});
      // shifter corners and the remaining opcodes, checked by the predictor
      add_row(dp_word(1'b0, OP_AND, 1'b1, 4'd4, imm_shift(5'd0, SHIFT_LSL)), 32'hF0F0_F0F1,
              32'h8000_0001, 8'd0, 1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b0, OP_EOR, 1'b1, 4'd5, imm_shift(5'd0, SHIFT_LSR)), 32'h1234_5678,
              32'h8000_0000, 8'd0, 1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b0, OP_ORR, 1'b1, 4'd6, imm_shift(5'd0, SHIFT_ASR)), 32'h0,
              32'h8765_4321, 8'd0, 1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b0, OP_BIC, 1'b1, 4'd7, imm_shift(5'd0, SHIFT_ROR)), 32'hFFFF_FFFF,
              32'h0000_0003, 8'd0, 1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b0, OP_ADC, 1'b1, 4'd8, reg_shift(SHIFT_LSL)), 32'h7FFF_FFFF,
              32'h0000_0001, 8'd0, 1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b0, OP_SBC, 1'b1, 4'd9, reg_shift(SHIFT_LSR)), 32'h0,
              32'h8000_0001, 8'd32, 1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b0, OP_RSC, 1'b1, 4'd10, reg_shift(SHIFT_ASR)), 32'h0000_0005,
              32'h9000_0000, 8'd40, 1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b0, OP_RSB, 1'b1, 4'd11, reg_shift(SHIFT_ROR)), 32'h8000_0000,
              32'hC000_0001, 8'd64, 1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b0, OP_ADD, 1'b1, 4'd12, reg_shift(SHIFT_LSL)), 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 8'd33, 1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b0, OP_TST, 1'b0, REG_PC, 12'h0), 32'h0, 32'h0, 8'd0,
              1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b0, OP_TEQ, 1'b0, 4'd0, reg_shift(SHIFT_ROR)), 32'h0F0F_0F0F,
              32'h0000_00F0, 8'd4, 1'b0, 32'h0, 1'b0, '0);
      // register-shift form with bit 7 set
      add_row(dp_word(1'b0, OP_CMP, 1'b0, 4'd1, {4'h3, 1'b1, SHIFT_LSR, 1'b1, 4'h2}),
              32'h0000_0100, 32'h0001_0000, 8'd8, 1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b1, OP_CMN, 1'b0, 4'd2, rot_imm(4'hF, 8'hFF)), 32'hFFFF_FC04,
              32'h0, 8'd0, 1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b0, OP_MOV, 1'b0, 4'd3, imm_shift(5'd31, SHIFT_LSL)), 32'h0,
              32'h0000_0001, 8'd0, 1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b0, OP_RSB, 1'b0, 4'd4, imm_shift(5'd31, SHIFT_ASR)), 32'h0000_0001,
              32'h8000_0000, 8'd0, 1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b0, OP_SUB, 1'b0, 4'd5, imm_shift(5'd16, SHIFT_ROR)), 32'h0000_0000,
              32'hDEAD_BEEF, 8'd0, 1'b0, 32'h0, 1'b0, '0);
      add_row(dp_word(1'b0, OP_EOR, 1'b1, REG_PC, imm_shift(5'd1, SHIFT_LSR)), 32'hAAAA_AAAA,
              32'h5555_5555, 8'd0, 1'b1, 32'h5000_0000, 1'b0, '0);
      add_row(dp_word(1'b0, OP_SBC, 1'b1, REG_PC, reg_shift(SHIFT_ASR)), 32'h0000_0010,
              32'h0000_0020, 8'd255, 1'b0, 32'hA000_0000, 1'b0, '0);

      // reset held first, then lowered between edges
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].stim, directed_rows[i].exact, directed_rows[i].want);
         if ($urandom_range(0, 1) == 0)
            idle_sender($urandom_range(1, 2));
      end

      // random instructions in bursts
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == HOLD_AT) begin
            // receiver holds off while the sender keeps pushing
            long_hold_req = 1'b1;
            burst_left = HOLD_BURST;
         end
         if (n == DRAIN_AT) begin
            idle_sender(1);
            while (pending_results.size() != 0)
               @(posedge clock);
         end
         send_item(random_instr(), 1'b0, '0);
         burst_left--;
         if (burst_left <= 0) begin
            idle_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
         end
      end
      idle_sender(1);

      // wait out the results, then stay quiet and watch for stray transfers
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d instructions (%0d from the table); %0d results checked,",
               items_sent, directed_rows.size(), results_checked);
      $display("  %0d saved-status restores, %0d unpredictable PC writes.",
               restores_seen, unpredictables_seen);
      if (fail_count == 0)
         $display("dp_alu_barrel_shifter_test OK");
      else
         $display("dp_alu_barrel_shifter_test NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------
   // Receiver stall pattern, with one long hold on request
   // ---------------------------------------------------------------
   initial begin
      int mode, span, hold_left;
      mode = 0;
      span = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
         end
         span--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 9) < 3);
               2:       rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         if (fail_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $display("%0t: result with nothing expected, expected none, actual %h",
                        $time, rsp_data);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("result_value", want.result_value, rsp_data.result_value);
            check_field("dest_reg", want.dest_reg, rsp_data.dest_reg);
            check_field("dest_write", want.dest_write, rsp_data.dest_write);
            check_field("flags_after", want.flags_after, rsp_data.flags_after);
            check_field("restore_status", want.restore_status, rsp_data.restore_status);
            check_field("unpredictable", want.unpredictable, rsp_data.unpredictable);
            results_checked++;
            if (want.restore_status)
               restores_seen++;
            if (want.unpredictable)
               unpredictables_seen++;
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  pending_results.size());
         $display("dp_alu_barrel_shifter_test NOT OK");
         $finish;
      end
   end

endmodule

// File: filelist.f
rtl/dpalu_pkg.sv
rtl/dpalu_shifter.sv
rtl/dpalu_core.sv
rtl/dp_alu_barrel_shifter.sv
bench/dp_alu_barrel_shifter_test.sv
